>>> hdl/edt_pkg.sv
// Shared types and constants for the Euclidean distance threshold block.
package edt_pkg;

    localparam int COORD_BITS    = 16;
    localparam int MAG_BITS      = 16;
    localparam int PROD_BITS     = 2 * MAG_BITS;
    localparam int SUM_BITS      = 41;
    localparam int ROOT_BITS     = (SUM_BITS + 1) / 2;
    localparam int DIST_BITS     = 20;
    localparam int THR_BITS      = 16;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [SUM_BITS-1:0]  SUM_MAX  = {SUM_BITS{1'b1}};
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD     = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_USE_THRESHOLD = CFG_IDX_BITS'(1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] coord_a;
        logic signed [COORD_BITS-1:0] coord_b;
        logic                         last;
    } in_item_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 within_res;
    } out_item_t;

    // Controls for the shared square and accumulate unit.
    typedef struct packed {
        logic load_sq;
        logic load_thr;
        logic add;
        logic clear;
    } mac_ctrl_t;

endpackage

>>> hdl/edt_mac.sv
// Shared squaring multiplier with a saturating sum-of-squares accumulator.
module edt_mac (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  edt_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [edt_pkg::COORD_BITS-1:0] coord_a,
    input  logic signed [edt_pkg::COORD_BITS-1:0] coord_b,
    input  logic [edt_pkg::THR_BITS-1:0]         threshold,
    output logic [edt_pkg::PROD_BITS-1:0]        prod,
    output logic [edt_pkg::SUM_BITS-1:0]         sum
);

    logic signed [edt_pkg::COORD_BITS:0]  diff;
    logic signed [edt_pkg::COORD_BITS:0]  diff_neg;
    logic [edt_pkg::MAG_BITS-1:0]         mag;
    logic [edt_pkg::MAG_BITS-1:0]         operand;
    logic [edt_pkg::PROD_BITS-1:0]        prod_reg;
    logic [edt_pkg::PROD_BITS-1:0]        prod_next;
    logic [edt_pkg::SUM_BITS-1:0]         sum_reg;
    logic [edt_pkg::SUM_BITS-1:0]         sum_next;
    logic [edt_pkg::SUM_BITS:0]           sum_wide;

    // The difference of two 16-bit values has a magnitude of at most 65535.
    assign diff     = {coord_a[edt_pkg::COORD_BITS-1], coord_a}
                    - {coord_b[edt_pkg::COORD_BITS-1], coord_b};
    assign diff_neg = -diff;
    assign mag      = diff[edt_pkg::COORD_BITS] ? diff_neg[edt_pkg::MAG_BITS-1:0]
                                                : diff[edt_pkg::MAG_BITS-1:0];
    assign operand  = ctrl.load_thr ? threshold : mag;

    always_comb begin
        prod_next = prod_reg;
        if (ctrl.load_sq || ctrl.load_thr) begin
            prod_next = operand * operand;
        end
    end

    assign sum_wide = {1'b0, sum_reg} + (edt_pkg::SUM_BITS + 1)'(prod_reg);

    always_comb begin
        sum_next = sum_reg;
        if (ctrl.clear) begin
            sum_next = '0;
        end else if (ctrl.add) begin
            sum_next = sum_wide[edt_pkg::SUM_BITS] ? edt_pkg::SUM_MAX
                                                   : sum_wide[edt_pkg::SUM_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

    assign prod = prod_reg;
    assign sum  = sum_reg;

endmodule

>>> hdl/edt_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module edt_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [edt_pkg::SUM_BITS-1:0]  x,
    output logic                          busy,
    output logic [edt_pkg::ROOT_BITS-1:0] root
);

    localparam logic [edt_pkg::SUM_BITS-1:0] BIT_INIT =
        edt_pkg::SUM_BITS'(1) << (2 * (edt_pkg::ROOT_BITS - 1));

    logic [edt_pkg::SUM_BITS-1:0] x_reg;
    logic [edt_pkg::SUM_BITS-1:0] x_next;
    logic [edt_pkg::SUM_BITS:0]   res_reg;
    logic [edt_pkg::SUM_BITS:0]   res_next;
    logic [edt_pkg::SUM_BITS-1:0] bit_reg;
    logic [edt_pkg::SUM_BITS-1:0] bit_next;
    logic [edt_pkg::SUM_BITS:0]   trial;

    assign trial = res_reg + {1'b0, bit_reg};
    assign busy  = (bit_reg != '0);

    always_comb begin
        x_next   = x_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        if (start) begin
            x_next   = x;
            res_next = '0;
            bit_next = BIT_INIT;
        end else if (busy) begin
            if ({1'b0, x_reg} >= trial) begin
                x_next   = x_reg - trial[edt_pkg::SUM_BITS-1:0];
                res_next = (res_reg >> 1) + {1'b0, bit_reg};
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        res_reg <= res_next;
        if (!aresetn) begin
            bit_reg <= '0;
        end else begin
            bit_reg <= bit_next;
        end
    end

    assign root = res_reg[edt_pkg::ROOT_BITS-1:0];

endmodule

>>> hdl/euclidean_distance_threshold_top.sv
// Top level of the Euclidean distance threshold block: sequencer, registers and result stage.
//
// Channel   Direction  Ports                                  Beat carries
// -------   ---------  -------------------------------------  ----------------------------
// input     in         s_valid, s_ready, s_data               coord_a, coord_b, last
// result    out        m_valid, m_ready, m_data               distance, within_res
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data  register index and value
//
// A beat without last is accepted, squared and accumulated.
// A beat with last goes on up to the load into the result stage: after the accept,
// square and accumulate steps, the threshold is squared, the sum is compared with it,
// the square root unit works out the root one result bit at a time, the sequencer sees
// the unit finish, and the result is loaded once the result stage can take it.
// The result stage holds one finished result, so a stalled m_ready blocks the next
// result only; input beats are taken meanwhile until a second result is ready to load.
// Reset is synchronous and active low; it clears the sum and loads the register defaults.
module euclidean_distance_threshold_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  edt_pkg::in_item_t                      s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output edt_pkg::out_item_t                     m_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [edt_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [edt_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_THR  = 3'd3;
    localparam logic [2:0] ST_CMP  = 3'd4;
    localparam logic [2:0] ST_ROOT = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]                         state_reg;
    logic [2:0]                         state_next;
    edt_pkg::in_item_t                  item_reg;
    edt_pkg::in_item_t                  item_next;
    logic [edt_pkg::THR_BITS-1:0]       threshold_reg;
    logic [edt_pkg::THR_BITS-1:0]       threshold_next;
    logic                               use_threshold_reg;
    logic                               use_threshold_next;
    logic                               within_reg;
    logic                               within_next;
    logic                               m_valid_reg;
    logic                               m_valid_next;
    edt_pkg::out_item_t                 m_data_reg;
    edt_pkg::out_item_t                 m_data_next;

    edt_pkg::mac_ctrl_t                 mac_ctrl;
    logic [edt_pkg::PROD_BITS-1:0]      prod;
    logic [edt_pkg::SUM_BITS-1:0]       acc_sum;
    logic                               root_start;
    logic                               root_busy;
    logic [edt_pkg::ROOT_BITS-1:0]      root;
    logic [edt_pkg::DIST_BITS-1:0]      dist_code;
    logic                               s_accept;
    logic                               out_load;

    edt_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (mac_ctrl),
        .coord_a   (item_reg.coord_a),
        .coord_b   (item_reg.coord_b),
        .threshold (threshold_reg),
        .prod      (prod),
        .sum       (acc_sum)
    );

    edt_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .x       (acc_sum),
        .busy    (root_busy),
        .root    (root)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // The result stage may load when it is empty or its beat leaves this cycle.
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // When thresholding is on and the sum is beyond the radius, the distance
    // saturates; otherwise the root is clamped to the 20-bit range.
    always_comb begin
        if (use_threshold_reg && !within_reg) begin
            dist_code = edt_pkg::DIST_MAX;
        end else if (root > edt_pkg::ROOT_BITS'(edt_pkg::DIST_MAX)) begin
            dist_code = edt_pkg::DIST_MAX;
        end else begin
            dist_code = root[edt_pkg::DIST_BITS-1:0];
        end
    end

    always_comb begin
        state_next  = state_reg;
        item_next   = item_reg;
        within_next = within_reg;
        mac_ctrl    = '0;
        root_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    item_next  = s_data;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                mac_ctrl.load_sq = 1'b1;
                state_next       = ST_ADD;
            end
            ST_ADD: begin
                mac_ctrl.add = 1'b1;
                state_next   = item_reg.last ? ST_THR : ST_IDLE;
            end
            ST_THR: begin
                mac_ctrl.load_thr = 1'b1;
                state_next        = ST_CMP;
            end
            ST_CMP: begin
                within_next = (acc_sum <= edt_pkg::SUM_BITS'(prod));
                root_start  = 1'b1;
                state_next  = ST_ROOT;
            end
            ST_ROOT: begin
                if (!root_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    mac_ctrl.clear = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes to an index outside the register list are dropped.
    always_comb begin
        threshold_next     = threshold_reg;
        use_threshold_next = use_threshold_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == edt_pkg::REG_THRESHOLD) begin
                threshold_next = cfg_data[edt_pkg::THR_BITS-1:0];
            end else if (cfg_index == edt_pkg::REG_USE_THRESHOLD) begin
                use_threshold_next = cfg_data[0];
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next           = 1'b1;
            m_data_next.distance   = dist_code;
            m_data_next.within_res = within_reg;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        within_reg <= within_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            threshold_reg     <= {edt_pkg::THR_BITS{1'b1}};
            use_threshold_reg <= 1'b1;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            threshold_reg     <= threshold_next;
            use_threshold_reg <= use_threshold_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The root unit is never left running while a new beat can be taken.
    a_idle_root_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !root_busy)
        else $error("square root unit busy while accepting input");

    // Delivering a result clears the sum for the next vector pair.
    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (acc_sum == '0))
        else $error("sum not cleared after result load");

    // With thresholding on, a result outside the radius carries the maximum code.
    a_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && use_threshold_reg && !m_data.within_res)
            |-> (m_data.distance == edt_pkg::DIST_MAX))
        else $error("distance not saturated beyond threshold");

endmodule

>>> verif/tb.sv
// Self-checking testbench for the Euclidean distance threshold block.
`timescale 1ns / 1ps

module tb;

    // The clock runs at 50 MHz, and reset is held low before the stimulus starts.
    localparam int HALF_PERIOD_NS = 10;
    localparam int RESET_CYCLES   = 12;

    // This covers the time that a beat with last needs before its result loads, with margin.
    localparam int SETTLE_CYCLES = 40;

    // The timeout leaves a wide margin over the slowest correct run.
    localparam longint TIMEOUT_NS = 10_000_000;

    // Input beats to send at least, counting the directed table.
    localparam int unsigned TOTAL_BEATS = 950;

    // 513 beats of the widest difference are enough to pass 2^41 - 1.
    // The sum then saturates and the square root clamps.
    localparam int unsigned SAT_LEN = 520;
    localparam int unsigned MAX_DIMS = 64;

    localparam logic [edt_pkg::THR_BITS-1:0] THR_RESET = 16'hFFFF;

    // Any register index above the last defined one is unused, and a write to it is ignored.
    localparam logic [edt_pkg::CFG_IDX_BITS-1:0] REG_SPARE =
        edt_pkg::REG_USE_THRESHOLD + 1'b1;

    // Handy Q8.8 coordinate values.
    localparam logic [edt_pkg::COORD_BITS-1:0] Q_ONE = 16'h0100;
    localparam logic [edt_pkg::COORD_BITS-1:0] C_MAX = 16'h7FFF;
    localparam logic [edt_pkg::COORD_BITS-1:0] C_MIN = 16'h8000;

    // ROW_BEAT rows are checked against the predictor.
    // ROW_CHECKED rows carry a result that is known by hand.
    // ROW_CFG rows write a register once the block has gone idle.
    typedef enum logic [1:0] {
        ROW_BEAT,
        ROW_CHECKED,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                           kind;
        logic [edt_pkg::CFG_IDX_BITS-1:0]    idx;
        logic [edt_pkg::CFG_DATA_BITS-1:0]   val;
        edt_pkg::in_item_t                   beat;
        edt_pkg::out_item_t                  known;
    } plan_row_t;

    // Ways to form the coordinate pairs of a random vector.
    typedef enum logic [1:0] {
        PAIR_WIDE,
        PAIR_NEAR,
        PAIR_CORNER,
        PAIR_MAXDIFF
    } pair_style_t;

    localparam edt_pkg::in_item_t  NO_BEAT = '0;
    localparam edt_pkg::out_item_t NO_DIST = '0;

    // Directed table.
    // The index and data fields are unused on beat rows, and the beat fields on register rows.
    localparam int PLAN_ROWS = 25;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // With the reset settings, the radius is the largest and saturation is on.
        '{ROW_CHECKED, '0, '0, '{16'h0000, 16'h0000, 1'b1}, '{20'd0, 1'b1}},
        '{ROW_CHECKED, '0, '0, '{Q_ONE, 16'h0000, 1'b1}, '{20'd256, 1'b1}},
        // These give the widest difference, whose square equals the squared radius exactly.
        '{ROW_CHECKED, '0, '0, '{C_MAX, C_MIN, 1'b1}, '{20'd65535, 1'b1}},
        '{ROW_CHECKED, '0, '0, '{C_MIN, C_MAX, 1'b1}, '{20'd65535, 1'b1}},
        // One step past the radius saturates the distance and clears the flag.
        '{ROW_BEAT, '0, '0, '{C_MAX, C_MIN, 1'b0}, NO_DIST},
        '{ROW_CHECKED, '0, '0, '{16'h0000, 16'h0001, 1'b1}, '{edt_pkg::DIST_MAX, 1'b0}},
        // A two-beat vector, 3 and 4, gives 5.
        '{ROW_BEAT, '0, '0, '{16'h0300, 16'h0000, 1'b0}, NO_DIST},
        '{ROW_CHECKED, '0, '0, '{16'h0000, 16'h0400, 1'b1}, '{20'h00500, 1'b1}},
        '{ROW_CHECKED, '0, '0, '{C_MIN, C_MIN, 1'b1}, '{20'd0, 1'b1}},
        '{ROW_CHECKED, '0, '0, '{C_MAX, C_MAX, 1'b1}, '{20'd0, 1'b1}},
        '{ROW_BEAT, '0, '0, '{16'hFFFF, 16'h0001, 1'b1}, NO_DIST},
        '{ROW_BEAT, '0, '0, '{16'h5A5A, 16'hA5A5, 1'b1}, NO_DIST},
        // With a zero radius, only equal vectors count as neighbors.
        '{ROW_CFG, edt_pkg::REG_THRESHOLD, 16'h0000, NO_BEAT, NO_DIST},
        '{ROW_CHECKED, '0, '0, '{16'h1234, 16'h1234, 1'b1}, '{20'd0, 1'b1}},
        '{ROW_CHECKED, '0, '0, '{16'h0001, 16'h0000, 1'b1}, '{edt_pkg::DIST_MAX, 1'b0}},
        // Only bit 0 of this data counts, so it turns saturation off.
        '{ROW_CFG, edt_pkg::REG_USE_THRESHOLD, 16'hFFFE, NO_BEAT, NO_DIST},
        '{ROW_CHECKED, '0, '0, '{16'h0001, 16'h0000, 1'b1}, '{20'd1, 1'b0}},
        // A write to an unused index must leave both registers alone.
        '{ROW_CFG, REG_SPARE, 16'hFFFF, NO_BEAT, NO_DIST},
        '{ROW_CHECKED, '0, '0, '{16'h0001, 16'h0000, 1'b1}, '{20'd1, 1'b0}},
        // With a radius of 1.0 and saturation back on, the test falls right at the edge.
        '{ROW_CFG, edt_pkg::REG_THRESHOLD, Q_ONE, NO_BEAT, NO_DIST},
        '{ROW_CFG, edt_pkg::REG_USE_THRESHOLD, 16'h0001, NO_BEAT, NO_DIST},
        '{ROW_CHECKED, '0, '0, '{Q_ONE, 16'h0000, 1'b1}, '{20'd256, 1'b1}},
        '{ROW_BEAT, '0, '0, '{16'h0080, 16'h0000, 1'b0}, NO_DIST},
        '{ROW_BEAT, '0, '0, '{16'h0000, 16'h00C0, 1'b1}, NO_DIST},
        '{ROW_CHECKED, '0, '0, '{16'h0101, 16'h0000, 1'b1}, '{edt_pkg::DIST_MAX, 1'b0}}
    };

    // Every input starts at a known value.
    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               s_valid   = 1'b0;
    logic                               s_ready;
    edt_pkg::in_item_t                  s_data    = '0;
    logic                               m_valid;
    logic                               m_ready   = 1'b0;
    edt_pkg::out_item_t                 m_data;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [edt_pkg::CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [edt_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // This is the predictor state, which mirrors the block.
    logic [edt_pkg::SUM_BITS-1:0]       sum_q     = '0;
    logic [edt_pkg::THR_BITS-1:0]       radius_q  = THR_RESET;
    logic                               clamp_on  = 1'b1;

    // These distances are expected, oldest first.
    edt_pkg::out_item_t                 dist_due_q [$];

    int unsigned               beats_sent  = 0;
    int unsigned               err_count   = 0;
    // When set, the sender or the receiver runs without any gaps.
    bit                        src_steady  = 1'b0;
    bit                        sink_steady = 1'b0;

    euclidean_distance_threshold_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD_NS) aclk = ~aclk;

    // This adds one pair into the running sum. On a beat with last, it works out the distance and
    // the neighbor flag, clears the sum and returns 1.
    function automatic bit predict_distance(input edt_pkg::in_item_t it,
                                            output edt_pkg::out_item_t res);
        logic signed [edt_pkg::COORD_BITS:0] diff;
        logic [31:0]                         mag;
        logic [edt_pkg::SUM_BITS:0]          grown;
        logic [31:0]                         radius_sq;
        logic [63:0]                         root;
        logic [63:0]                         trial;
        logic                                near;
        diff = $signed({it.coord_a[edt_pkg::COORD_BITS-1], it.coord_a})
             - $signed({it.coord_b[edt_pkg::COORD_BITS-1], it.coord_b});
        mag = (diff < 0) ? 32'(-diff) : 32'(diff);
        grown = (edt_pkg::SUM_BITS+1)'(sum_q) + (edt_pkg::SUM_BITS+1)'(mag * mag);
        // A carry out of the sum means that it has saturated.
        sum_q = grown[edt_pkg::SUM_BITS] ? edt_pkg::SUM_MAX : grown[edt_pkg::SUM_BITS-1:0];
        res = '0;
        if (!it.last) begin
            return 1'b0;
        end
        radius_sq = 32'(radius_q) * 32'(radius_q);
        near = (sum_q <= edt_pkg::SUM_BITS'(radius_sq));
        // The square root is built one bit at a time, from the top down. The root of 2^41
        // fits in 21 bits.
        root = '0;
        for (int b = edt_pkg::ROOT_BITS - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= 64'(sum_q)) begin
                root = trial;
            end
        end
        if (clamp_on && !near) begin
            res.distance = edt_pkg::DIST_MAX;
        end else begin
            res.distance = (root > 64'(edt_pkg::DIST_MAX)) ? edt_pkg::DIST_MAX
                                                          : root[edt_pkg::DIST_BITS-1:0];
        end
        res.within_res = near;
        sum_q = '0;
        return 1'b1;
    endfunction

    // Most gaps are short, and a few are long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(3, 1);
        end
        if (r < 97) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(40, 20);
    endfunction

    function automatic logic [edt_pkg::COORD_BITS-1:0] corner_coord();
        case ($urandom_range(5))
            0: begin
                return C_MAX;
            end
            1: begin
                return C_MIN;
            end
            2: begin
                return 16'h0000;
            end
            3: begin
                return 16'hFFFF;
            end
            4: begin
                return 16'h0001;
            end
            default: begin
                return Q_ONE;
            end
        endcase
    endfunction

    function automatic edt_pkg::in_item_t make_pair(input pair_style_t style,
                                                    input int unsigned span, input bit last);
        edt_pkg::in_item_t p;
        bit                flip;
        p.last = last;
        case (style)
            PAIR_WIDE: begin
                p.coord_a = 16'($urandom);
                p.coord_b = 16'($urandom);
            end
            PAIR_NEAR: begin
                // The offset wraps in 16 bits, so now and then it also gives a wide difference.
                p.coord_a = 16'($urandom);
                p.coord_b = p.coord_a + 16'(int'($urandom_range(2 * span)) - int'(span));
            end
            PAIR_CORNER: begin
                p.coord_a = corner_coord();
                p.coord_b = corner_coord();
            end
            default: begin
                flip = 1'($urandom_range(1));
                p.coord_a = flip ? C_MIN : C_MAX;
                p.coord_b = flip ? C_MAX : C_MIN;
            end
        endcase
        return p;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        err_count++;
    endtask

    // This presents one beat after a random gap and waits until the block takes it. Valid stays
    // high after the handshake, so a following beat can go out with no gap.
    task automatic send_beat(input edt_pkg::in_item_t it, input bit known,
                             input edt_pkg::out_item_t known_res);
        edt_pkg::out_item_t res;
        int unsigned        gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        // The predictor always runs, so its sum stays in step even on rows checked by hand.
        if (predict_distance(it, res)) begin
            dist_due_q.push_back(known ? known_res : res);
        end
    endtask

    // Set "more" when another write follows at once, so that valid is not lowered in between.
    task automatic write_reg(input logic [edt_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [edt_pkg::CFG_DATA_BITS-1:0] val, input bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            edt_pkg::REG_THRESHOLD: begin
                radius_q = val;
            end
            edt_pkg::REG_USE_THRESHOLD: begin
                clamp_on = val[0];
            end
            default: begin
            end
        endcase
        if (!more) begin
            cfg_valid <= 1'b0;
        end
    endtask

    // This holds the sender back until every result that is owed has arrived. It always waits
    // for the clock, so valid is never lowered and raised in the same time step.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (dist_due_q.size() != 0);
    endtask

    // A beat without last may still be inside the block, so wait out its latency as well.
    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The receiver keeps ready high for a short run, then, unless sink_steady is set, stalls for a random time.
    initial begin : result_pacing
        int unsigned stall;
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(8, 1)) @(posedge aclk);
            stall = sink_steady ? 0 : pick_gap();
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Each result beat is compared with the oldest expected one, field by field.
    always @(posedge aclk) begin : result_check
        edt_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (dist_due_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: distance %0d within %0b",
                                          m_data.distance, m_data.within_res));
            end else begin
                want = dist_due_q.pop_front();
                if (m_data.distance !== want.distance) begin
                    report_mismatch($sformatf("distance %0d, expected %0d",
                                              m_data.distance, want.distance));
                end
                if (m_data.within_res !== want.within_res) begin
                    report_mismatch($sformatf("within_res %0b, expected %0b",
                                              m_data.within_res, want.within_res));
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned                    phase;
        int unsigned                    nvec;
        int unsigned                    len;
        int unsigned                    span;
        int unsigned                    pick;
        pair_style_t                    style;
        logic [edt_pkg::THR_BITS-1:0]   radius;
        bit                             spare_wr;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The directed table comes first. Register rows wait for the block to go idle.
        for (int r = 0; r < PLAN_ROWS; r++) begin
            case (PLAN[r].kind)
                ROW_CFG: begin
                    if (r == 0 || PLAN[r-1].kind != ROW_CFG) begin
                        wait_idle();
                    end
                    write_reg(PLAN[r].idx, PLAN[r].val,
                              (r + 1 < PLAN_ROWS) && (PLAN[r+1].kind == ROW_CFG));
                end
                ROW_CHECKED: begin
                    send_beat(PLAN[r].beat, 1'b1, PLAN[r].known);
                end
                default: begin
                    send_beat(PLAN[r].beat, 1'b0, NO_DIST);
                end
            endcase
        end

        // Random phases follow. Each one starts from idle with new settings.
        phase = 0;
        while (beats_sent < TOTAL_BEATS) begin
            wait_idle();
            if (phase == 2) begin
                // Drive the sum into saturation with the clamp off, so the square root must clamp.
                write_reg(edt_pkg::REG_THRESHOLD, 16'($urandom), 1'b1);
                write_reg(edt_pkg::REG_USE_THRESHOLD, {15'($urandom), 1'b0}, 1'b0);
                src_steady  = 1'b1;
                sink_steady = 1'b0;
                for (int unsigned i = 0; i < SAT_LEN; i++) begin
                    send_beat(make_pair(PAIR_MAXDIFF, 0, i == SAT_LEN - 1), 1'b0, NO_DIST);
                end
            end else begin
                // The first two phases cover the largest and the smallest radius.
                if (phase == 0) begin
                    radius = '1;
                end else if (phase == 1) begin
                    radius = '0;
                end else begin
                    case ($urandom_range(3))
                        0: begin
                            radius = '0;
                        end
                        1: begin
                            radius = '1;
                        end
                        2: begin
                            radius = 16'($urandom);
                        end
                        default: begin
                            radius = 16'($urandom) >> $urandom_range(15);
                        end
                    endcase
                end
                spare_wr = ($urandom_range(3) == 0);
                write_reg(edt_pkg::REG_THRESHOLD, radius, 1'b1);
                write_reg(edt_pkg::REG_USE_THRESHOLD, 16'($urandom), spare_wr);
                if (spare_wr) begin
                    write_reg(edt_pkg::CFG_IDX_BITS'($urandom_range(
                                  2**edt_pkg::CFG_IDX_BITS - 1, REG_SPARE)),
                              16'($urandom), 1'b0);
                end
                src_steady  = ($urandom_range(3) == 0);
                sink_steady = ($urandom_range(3) == 0);
                nvec = $urandom_range(12, 3);
                for (int unsigned v = 0; v < nvec; v++) begin
                    // Now and then, and once for certain, the sender stops until every
                    // result that is owed has come back.
                    if ((phase == 1 && v == nvec / 2) || $urandom_range(15) == 0) begin
                        drain_results();
                    end
                    // Most vectors are short. A few reach the full dimension.
                    pick = $urandom_range(9);
                    if (pick < 4) begin
                        len = 1;
                    end else if (pick < 8) begin
                        len = $urandom_range(8, 2);
                    end else if (pick == 8) begin
                        len = $urandom_range(32, 9);
                    end else begin
                        len = $urandom_range(MAX_DIMS, 33);
                    end
                    pick = $urandom_range(9);
                    if (pick < 3) begin
                        style = PAIR_WIDE;
                    end else if (pick < 8) begin
                        style = PAIR_NEAR;
                    end else if (pick == 8) begin
                        style = PAIR_CORNER;
                    end else begin
                        style = PAIR_MAXDIFF;
                    end
                    // Differences on a random scale land on both sides of the test.
                    span = 1 << $urandom_range(14);
                    for (int unsigned i = 0; i < len; i++) begin
                        send_beat(make_pair(style, span, i == len - 1), 1'b0, NO_DIST);
                    end
                end
            end
            phase++;
        end

        // Wait until the last result is in, then give stray beats time to show up.
        src_steady = 1'b0;
        wait_idle();
        if (err_count == 0 && dist_due_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("tb failed");
        $finish;
    end

endmodule
